// ----- hdl/hts_pkg.sv -----
// Shared types and constants of the static Huffman tree stream decoder.
`default_nettype none
package hts_pkg;
    localparam int DEF_MAX_RECORDS = 512;
    localparam int ENTRY_W         = 19;
    localparam int LEAF_BIT        = 18;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER    = 3'd1;
    localparam logic [2:0] ST_SIZE_MISMATCH = 3'd2;
    localparam logic [2:0] ST_BAD_RECORD    = 3'd3;
    localparam logic [2:0] ST_BAD_COUNT     = 3'd4;
    localparam logic [2:0] ST_SHORT         = 3'd5;
    localparam logic [2:0] ST_WALK_FAIL     = 3'd6;

    localparam logic CFG_INPUT_LENGTH  = 1'b0;
    localparam logic CFG_OUTPUT_LENGTH = 1'b1;

    localparam logic [27:0] MIN_IN_LEN   = 28'd11;
    localparam logic [27:0] MAX_IN_LEN   = 28'h8000000;
    localparam logic [31:0] MAX_OUT_SIZE = 32'h10000000;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_in_run;
        logic       finished;
        logic [2:0] status;
    } res_t;
endpackage
`default_nettype wire

// ----- hdl/hts_node_mem.sv -----
// Node table: one write port, one registered read port.
`default_nettype none
module hts_node_mem #(
    parameter int MAX_RECORDS = hts_pkg::DEF_MAX_RECORDS,
    parameter int AW          = $clog2(MAX_RECORDS)
) (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [AW-1:0]                wr_addr,
    input  wire logic [hts_pkg::ENTRY_W-1:0]  wr_data,
    input  wire logic                         rd_en,
    input  wire logic [AW-1:0]                rd_addr,
    output logic      [hts_pkg::ENTRY_W-1:0]  rd_data
);
    import hts_pkg::*;

    logic [ENTRY_W-1:0] mem_reg [MAX_RECORDS];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
`default_nettype wire

// ----- hdl/hts_hdr_check.sv -----
// Header field checks: size, node count, root, input length, output length.
`default_nettype none
module hts_hdr_check #(
    parameter int MAX_RECORDS = hts_pkg::DEF_MAX_RECORDS
) (
    input  wire logic [63:0] header,
    input  wire logic [27:0] input_length,
    input  wire logic [28:0] output_length,
    output logic      [2:0]  status
);
    import hts_pkg::*;

    logic [31:0] size;
    logic [15:0] nodes;
    logic [15:0] root;
    logic [9:0]  rc;
    logic [14:0] prod;
    logic [14:0] tree_bytes;
    logic [33:0] rhs;
    logic [27:0] lhs;

    always_comb begin
        size       = header[31:0];
        nodes      = header[47:32];
        root       = header[63:48];
        rc         = nodes[9:0] + 10'd1;
        prod       = 15'(rc) * 15'd21;
        tree_bytes = (prod + 15'd7) >> 3;
        rhs        = 34'(size) + 34'(tree_bytes) + 34'd16;
        lhs        = input_length - 28'd8;
        priority if (size == 32'd0 || size > MAX_OUT_SIZE || nodes < 16'd3
                     || nodes > 16'(MAX_RECORDS - 1)) begin
            status = ST_BAD_HEADER;
        end else if (root >= {6'd0, rc}) begin
            status = ST_BAD_HEADER;
        end else if (34'(lhs) > rhs) begin
            status = ST_BAD_HEADER;
        end else if ({3'd0, output_length} != size) begin
            status = ST_SIZE_MISMATCH;
        end else begin
            status = ST_OK;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/huffman_tree_stream_decoder.sv -----
// Top level: static Huffman tree stream decoder, header, tree load and tree walk.
// Header bytes are gathered in turn; the eighth goes on to the field checks, then returns.
// Tree bytes: accept, one record bit per cycle while the output is free, tail check,
// close; the byte that ends the table adds the root read and root check. Payload bytes:
// each bit waits on one node-table read. A stalled result request holds the byte longer.
// Synchronous active-low reset returns to the header phase; the table keeps its contents.
`default_nettype none
module huffman_tree_stream_decoder #(
    parameter int MAX_RECORDS = hts_pkg::DEF_MAX_RECORDS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // symbol
    output logic             m_tlast,   // last_in_run
    output logic      [3:0]  m_tuser,   // finished, status[2:0]
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [28:0] cfg_wdata
);
    import hts_pkg::*;

    localparam int AW = $clog2(MAX_RECORDS);

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_TREE    = 3'd1;
    localparam logic [2:0] PH_PAYLOAD = 3'd2;
    localparam logic [2:0] PH_DONE    = 3'd3;
    localparam logic [2:0] PH_ERROR   = 3'd4;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_HDRCHK  = 3'd1;
    localparam logic [2:0] S_BIT     = 3'd2;
    localparam logic [2:0] S_WAIT    = 3'd3;
    localparam logic [2:0] S_ROOTRD  = 3'd4;
    localparam logic [2:0] S_ROOTCHK = 3'd5;
    localparam logic [2:0] S_TAIL    = 3'd6;
    localparam logic [2:0] S_END     = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [2:0]          phase_reg, phase_next;
    logic [7:0]          byte_reg, byte_next;
    logic [2:0]          bit_reg, bit_next;
    logic [27:0]         bytes_seen_reg, bytes_seen_next;
    logic [63:0]         header_reg, header_next;
    logic [20:0]         acc_reg, acc_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic [9:0]          rec_pos_reg, rec_pos_next;
    logic [9:0]          tally_reg, tally_next;
    logic [ENTRY_W-1:0]  cur_reg, cur_next;
    logic [ENTRY_W-1:0]  root_entry_reg, root_entry_next;
    logic [9:0]          guard_reg, guard_next;
    logic [28:0]         emitted_reg, emitted_next;
    logic [31:0]         cons_reg, cons_next;
    logic [3:0]          n_reg, n_next;
    res_t                pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    res_t                out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic [27:0]         in_len_reg, in_len_next;
    logic [28:0]         out_len_reg, out_len_next;

    // node table port
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [ENTRY_W-1:0]  mem_rdata;

    logic [2:0]          hdr_status;
    logic [31:0]         size;
    logic [15:0]         nodes;
    logic [15:0]         root;
    logic [9:0]          rc;
    logic                v;
    logic [20:0]         acc_new;
    logic [4:0]          cnt_new;
    logic                rec_done;
    logic [9:0]          one_code;
    logic [9:0]          zero_code;
    logic [9:0]          tally_new;
    logic [9:0]          rec_new;
    logic [9:0]          guard_new;
    logic [8:0]          child;
    logic [28:0]         emitted_new;
    logic                fin;
    logic                out_free;
    logic                advance;
    logic                fail_req;
    logic [2:0]          fail_code;
    logic                push;
    res_t                push_data;

    hts_node_mem #(
        .MAX_RECORDS (MAX_RECORDS),
        .AW          (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    hts_hdr_check #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_hdr (
        .header        (header_reg),
        .input_length  (in_len_reg),
        .output_length (out_len_reg),
        .status        (hdr_status)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.symbol;
    assign m_tlast  = out_reg.last_in_run;
    assign m_tuser  = {out_reg.status, out_reg.finished};

    always_comb begin
        // header fields and the current bit
        size      = header_reg[31:0];
        nodes     = header_reg[47:32];
        root      = header_reg[63:48];
        rc        = nodes[9:0] + 10'd1;
        v         = byte_reg[bit_reg];
        acc_new   = acc_reg | (21'(v) << cnt_reg);
        cnt_new   = cnt_reg + 5'd1;
        rec_done  = acc_new[0] ? (cnt_new >= 5'd9) : (cnt_new >= 5'd21);
        one_code  = acc_new[10:1];
        zero_code = acc_new[20:11];
        tally_new = tally_reg;
        rec_new   = rec_pos_reg + 10'd1;
        guard_new = guard_reg + 10'd1;
        child     = v ? cur_reg[17:9] : cur_reg[8:0];
        emitted_new = emitted_reg + 29'd1;
        fin       = ({3'd0, emitted_new} >= size);
        out_free  = !out_valid_reg || m_tready;

        state_next      = state_reg;
        phase_next      = phase_reg;
        byte_next       = byte_reg;
        bit_next        = bit_reg;
        bytes_seen_next = bytes_seen_reg;
        header_next     = header_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        rec_pos_next    = rec_pos_reg;
        tally_next      = tally_reg;
        cur_next        = cur_reg;
        root_entry_next = root_entry_reg;
        guard_next      = guard_reg;
        emitted_next    = emitted_reg;
        cons_next       = cons_reg;
        n_next          = n_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        in_len_next     = in_len_reg;
        out_len_next    = out_len_reg;

        mem_we    = 1'b0;
        mem_waddr = rec_pos_reg[AW-1:0];
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = child[AW-1:0];
        advance   = 1'b0;
        fail_req  = 1'b0;
        fail_code = ST_OK;
        push      = 1'b0;
        push_data = pend_reg;

        // drop the output once taken
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_INPUT_LENGTH:  in_len_next  = cfg_wdata[27:0];
                CFG_OUTPUT_LENGTH: out_len_next = cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    byte_next = s_tdata;
                    bit_next  = 3'd7;
                    n_next    = 4'd0;
                    if (phase_reg == PH_HEADER) begin
                        if (in_len_reg < MIN_IN_LEN || in_len_reg > MAX_IN_LEN) begin
                            fail_req  = 1'b1;
                            fail_code = ST_BAD_HEADER;
                        end else begin
                            // little-endian header, byte k lands at bits 8k up
                            header_next = header_reg
                                | (64'(s_tdata) << {bytes_seen_reg[2:0], 3'b000});
                            bytes_seen_next = bytes_seen_reg + 28'd1;
                            if (bytes_seen_reg == 28'd7) begin
                                state_next = S_HDRCHK;
                            end
                        end
                    end else if (phase_reg == PH_TREE || phase_reg == PH_PAYLOAD) begin
                        bytes_seen_next = bytes_seen_reg + 28'd1;
                        state_next      = S_BIT;
                    end
                end
            end

            S_HDRCHK: begin
                if (out_free) begin
                    if (hdr_status != ST_OK) begin
                        fail_req  = 1'b1;
                        fail_code = hdr_status;
                    end else begin
                        phase_next   = PH_TREE;
                        acc_next     = '0;
                        cnt_next     = '0;
                        rec_pos_next = '0;
                        tally_next   = '0;
                        state_next   = S_IDLE;
                    end
                end
            end

            S_BIT: begin
                if (out_free) begin
                    if (phase_reg == PH_TREE) begin
                        acc_next = acc_new;
                        cnt_next = cnt_new;
                        advance  = 1'b1;
                        if (rec_done) begin
                            if (acc_new[0]) begin
                                // leaf record: flag and 8-bit symbol
                                mem_we    = 1'b1;
                                mem_wdata = {1'b1, 10'd0, acc_new[8:1]};
                            end else if (!one_code[0] || !zero_code[0]) begin
                                fail_req  = 1'b1;
                                fail_code = ST_BAD_RECORD;
                            end else if ({1'b0, one_code[9:1]} >= rc
                                         || {1'b0, zero_code[9:1]} >= rc) begin
                                fail_req  = 1'b1;
                                fail_code = ST_BAD_RECORD;
                            end else begin
                                mem_we     = 1'b1;
                                mem_wdata  = {1'b0, one_code[9:1], zero_code[9:1]};
                                tally_new  = tally_reg + 10'd1;
                                tally_next = tally_new;
                            end
                            if (!fail_req) begin
                                rec_pos_next = rec_new;
                                acc_next     = '0;
                                cnt_next     = '0;
                                if (rec_new >= rc) begin
                                    if (tally_new != {1'b0, nodes[9:1]}) begin
                                        fail_req  = 1'b1;
                                        fail_code = ST_BAD_COUNT;
                                    end else begin
                                        advance    = 1'b0;
                                        state_next = S_ROOTRD;
                                        cons_next  = 32'({bytes_seen_reg - 28'd1, 3'b000})
                                                   + 32'(4'd8 - {1'b0, bit_reg});
                                    end
                                end
                            end
                        end
                    end else if (phase_reg == PH_PAYLOAD) begin
                        if (guard_new > rc) begin
                            fail_req  = 1'b1;
                            fail_code = ST_WALK_FAIL;
                        end else begin
                            mem_re     = 1'b1;
                            mem_raddr  = child[AW-1:0];
                            guard_next = guard_new;
                            state_next = S_WAIT;
                        end
                    end else begin
                        state_next = S_END;
                    end
                end
            end

            S_WAIT: begin
                if (out_free) begin
                    advance = 1'b1;
                    if (mem_rdata[LEAF_BIT]) begin
                        if (pend_valid_reg) begin
                            push      = 1'b1;
                            push_data = pend_reg;
                            push_data.last_in_run = 1'b0;
                        end
                        pend_next.symbol      = mem_rdata[7:0];
                        pend_next.last_in_run = 1'b0;
                        pend_next.finished    = fin;
                        pend_next.status      = ST_OK;
                        pend_valid_next       = 1'b1;
                        n_next                = n_reg + 4'd1;
                        emitted_next          = emitted_new;
                        cur_next              = root_entry_reg;
                        guard_next            = '0;
                        if (fin) begin
                            // leftover bits of this byte are dropped
                            phase_next = PH_DONE;
                            advance    = 1'b0;
                            state_next = S_END;
                        end
                    end else begin
                        cur_next = mem_rdata;
                    end
                end
            end

            S_ROOTRD: begin
                mem_re     = 1'b1;
                mem_raddr  = root[AW-1:0];
                state_next = S_ROOTCHK;
            end

            S_ROOTCHK: begin
                if (out_free) begin
                    if (mem_rdata[LEAF_BIT]) begin
                        fail_req  = 1'b1;
                        fail_code = ST_BAD_RECORD;
                    end else if ({2'b00, in_len_reg, 3'b000}
                                 < (33'(cons_reg) + 33'(size))) begin
                        fail_req  = 1'b1;
                        fail_code = ST_SHORT;
                    end else begin
                        phase_next      = PH_PAYLOAD;
                        cur_next        = mem_rdata;
                        root_entry_next = mem_rdata;
                        guard_next      = '0;
                        emitted_next    = '0;
                        advance         = 1'b1;
                    end
                end
            end

            S_TAIL: begin
                if (out_free) begin
                    if ((phase_reg == PH_TREE || phase_reg == PH_PAYLOAD)
                        && bytes_seen_reg >= in_len_reg) begin
                        fail_req  = 1'b1;
                        fail_code = ST_SHORT;
                    end else begin
                        state_next = S_END;
                    end
                end
            end

            S_END: begin
                if (out_free) begin
                    if (pend_valid_reg) begin
                        push      = 1'b1;
                        push_data = pend_reg;
                        push_data.last_in_run = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase

        // advance to the next bit of the byte, or close the byte
        if (advance) begin
            if (bit_reg == 3'd0) begin
                state_next = S_TAIL;
            end else begin
                bit_next   = bit_reg - 3'd1;
                state_next = S_BIT;
            end
        end

        // an error is the final request of the byte; with eight symbols
        // already decoded it takes the place of the eighth
        if (fail_req) begin
            if (pend_valid_reg && n_reg < 4'd8) begin
                push      = 1'b1;
                push_data = pend_reg;
                push_data.last_in_run = 1'b0;
            end
            pend_next.symbol      = 8'd0;
            pend_next.last_in_run = 1'b0;
            pend_next.finished    = 1'b0;
            pend_next.status      = fail_code;
            pend_valid_next       = 1'b1;
            phase_next            = PH_ERROR;
            state_next            = S_END;
            mem_we                = 1'b0;
        end

        if (push) begin
            out_next       = push_data;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_HEADER;
            bytes_seen_reg <= '0;
            header_reg     <= '0;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            rec_pos_reg    <= '0;
            tally_reg      <= '0;
            guard_reg      <= '0;
            emitted_reg    <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            in_len_reg     <= MIN_IN_LEN;
            out_len_reg    <= 29'd1;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            bytes_seen_reg <= bytes_seen_next;
            header_reg     <= header_next;
            acc_reg        <= acc_next;
            cnt_reg        <= cnt_next;
            rec_pos_reg    <= rec_pos_next;
            tally_reg      <= tally_next;
            guard_reg      <= guard_next;
            emitted_reg    <= emitted_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            in_len_reg     <= in_len_next;
            out_len_reg    <= out_len_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        byte_reg       <= byte_next;
        bit_reg        <= bit_next;
        cur_reg        <= cur_next;
        root_entry_reg <= root_entry_next;
        cons_reg       <= cons_next;
        pend_reg       <= pend_next;
        out_reg        <= out_next;
    end
endmodule
`default_nettype wire

// ----- bench/hts_checker.sv -----
// Checker for the Huffman tree stream decoder: predicts results per accepted request and compares.
`default_nettype none
module hts_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,
    input  wire logic        m_tlast,
    input  wire logic [3:0]  m_tuser,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [28:0] cfg_wdata,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import hts_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER, PH_TREE, PH_PAYLOAD, PH_DONE, PH_ERROR
    } phase_t;

    logic [18:0] node_mem [DEF_MAX_RECORDS];
    phase_t      ph;
    logic [27:0] byte_count;
    logic [63:0] hdr;
    logic [20:0] acc;
    logic [4:0]  acc_bits;
    logic [9:0]  rec_pos;
    logic [9:0]  inner_count;
    logic [8:0]  cur_node;
    logic [9:0]  guard;
    logic [28:0] sym_count;
    logic [27:0] in_len;
    logic [28:0] out_len;

    res_t symbols_due [$];
    res_t byte_res [8];
    int   n_res;

    function void raise_error(logic [2:0] st);
        if (n_res >= 8) n_res = 7;
        byte_res[n_res] = '{8'h00, 1'b1, 1'b0, st};
        n_res++;
        ph = PH_ERROR;
    endfunction

    // Shift one bit into the record being loaded; store it once complete; check the table after the last one.
    function logic [2:0] load_tree_bit(logic v, longint unsigned consumed);
        int unsigned rc;
        int unsigned need;
        logic [9:0]  one;
        logic [9:0]  zero;
        rc = int'(hdr[47:32]) + 1;
        acc = acc | (21'(v) << acc_bits);
        acc_bits++;
        need = acc[0] ? 9 : 21;
        if (acc_bits < need) return ST_OK;
        if (rec_pos >= DEF_MAX_RECORDS || rec_pos >= rc) return ST_BAD_RECORD;
        if (acc[0]) begin
            node_mem[rec_pos[8:0]] = {1'b1, 10'd0, acc[8:1]};
        end else begin
            one  = acc[10:1];
            zero = acc[20:11];
            if (!one[0] || !zero[0]) return ST_BAD_RECORD;
            if (one[9:1] >= rc || zero[9:1] >= rc) return ST_BAD_RECORD;
            node_mem[rec_pos[8:0]] = {1'b0, one[9:1], zero[9:1]};
            inner_count++;
        end
        rec_pos++;
        acc = '0;
        acc_bits = '0;
        if (rec_pos < rc) return ST_OK;
        if (inner_count != hdr[47:32] / 2) return ST_BAD_COUNT;
        if (node_mem[hdr[56:48]][LEAF_BIT]) return ST_BAD_RECORD;
        if (longint'(in_len) * 8 < consumed + longint'(hdr[31:0])) return ST_SHORT;
        ph = PH_PAYLOAD;
        cur_node = hdr[56:48];
        guard = '0;
        sym_count = '0;
        return ST_OK;
    endfunction

    // Work out the results that one compressed byte causes.
    function void decode_byte(logic [7:0] b);
        longint      size;
        longint      nc;
        longint      tree_bytes;
        logic [2:0]  st;
        logic [18:0] e;
        logic        fin;
        n_res = 0;
        if (ph == PH_DONE || ph == PH_ERROR) return;
        if (ph == PH_HEADER) begin
            if (in_len < MIN_IN_LEN || in_len > MAX_IN_LEN) begin
                raise_error(ST_BAD_HEADER);
                return;
            end
            hdr = hdr | (64'(b) << (8 * byte_count[2:0]));
            byte_count++;
            if (byte_count < 8) return;
            size = longint'(hdr[31:0]);
            nc   = longint'(hdr[47:32]);
            if (size == 0 || size > MAX_OUT_SIZE || nc < 3 || nc > DEF_MAX_RECORDS - 1 ||
                longint'(hdr[63:48]) >= nc + 1) begin
                raise_error(ST_BAD_HEADER);
                return;
            end
            tree_bytes = ((nc + 1) * 21 + 7) / 8;
            if (longint'(in_len) - 8 > size + tree_bytes + 16) begin
                raise_error(ST_BAD_HEADER);
                return;
            end
            if (longint'(out_len) != size) begin
                raise_error(ST_SIZE_MISMATCH);
                return;
            end
            ph = PH_TREE;
            acc = '0;
            acc_bits = '0;
            rec_pos = '0;
            inner_count = '0;
            return;
        end
        byte_count++;
        for (int i = 7; i >= 0 && ph != PH_DONE; i--) begin
            if (ph == PH_TREE) begin
                st = load_tree_bit(b[i], (longint'(byte_count) - 1) * 8 + (8 - i));
                if (st != ST_OK) begin
                    raise_error(st);
                    return;
                end
            end else begin
                guard++;
                if (int'(guard) > int'(hdr[47:32]) + 1) begin
                    raise_error(ST_WALK_FAIL);
                    return;
                end
                e = node_mem[cur_node];
                cur_node = b[i] ? e[17:9] : e[8:0];
                e = node_mem[cur_node];
                if (e[LEAF_BIT]) begin
                    sym_count++;
                    fin = (sym_count >= hdr[31:0]);
                    if (n_res < 8) begin
                        byte_res[n_res] = '{e[7:0], 1'b0, fin, ST_OK};
                        n_res++;
                    end
                    cur_node = hdr[56:48];
                    guard = '0;
                    if (fin) ph = PH_DONE;
                end
            end
        end
        if (ph != PH_DONE && byte_count >= in_len) begin
            raise_error(ST_SHORT);
            return;
        end
        if (n_res > 0) byte_res[n_res - 1].last_in_run = 1'b1;
    endfunction

    function void report(string what, res_t exp_r, res_t got);
        fail_count++;
        if (fail_count <= 10)
            $display({"%0t: %s: expected sym %02h last %0b fin %0b st %0d, ",
                      "got sym %02h last %0b fin %0b st %0d"},
                     $realtime, what, exp_r.symbol, exp_r.last_in_run, exp_r.finished,
                     exp_r.status, got.symbol, got.last_in_run, got.finished, got.status);
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
        foreach (node_mem[i]) node_mem[i] = '0;
    end

    always @(posedge aclk) begin
        res_t got;
        res_t exp_r;
        if (!aresetn) begin
            ph = PH_HEADER;
            byte_count = '0;
            hdr = '0;
            acc = '0;
            acc_bits = '0;
            rec_pos = '0;
            inner_count = '0;
            cur_node = '0;
            guard = '0;
            sym_count = '0;
            in_len = 28'd11;
            out_len = 29'd1;
            symbols_due.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_INPUT_LENGTH) in_len = cfg_wdata[27:0];
                else out_len = cfg_wdata;
            end
            if (m_tvalid && m_tready) begin
                got = '{m_tdata, m_tlast, m_tuser[0], m_tuser[3:1]};
                if (symbols_due.size() == 0) begin
                    report("result with nothing expected", '0, got);
                end else begin
                    exp_r = symbols_due.pop_front();
                    if (got !== exp_r) report("result mismatch", exp_r, got);
                end
            end
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata);
                for (int k = 0; k < n_res; k++) symbols_due.push_back(byte_res[k]);
            end
        end
        pending = symbols_due.size();
    end
endmodule
`default_nettype wire

// ----- bench/tb_huffman_tree_stream_decoder.sv -----
// Testbench top: builds one compressed stream, drives it with bursts and stalls, gives the verdict.
`default_nettype none
module tb_huffman_tree_stream_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import hts_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 60;    // a payload byte may give nothing

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // data_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // symbol
    logic        m_tlast;   // last_in_run
    logic [3:0]  m_tuser;   // finished, status[2:0]
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [28:0] cfg_wdata;

    int fail_count;
    int pending;
    int cycles = 0;

    // Stream under test and the register values it needs.
    logic [7:0]  stream_q [$];
    logic [27:0] stream_len;
    logic [28:0] stream_size;

    int burst_left = 0;
    int rx_mode = 0;
    int rx_left = 0;

    always #4 aclk = ~aclk;

    huffman_tree_stream_decoder DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    hts_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending(pending)
    );

    // Receiver: switch between always ready, coin-flip and mostly stalled.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_left = $urandom_range(32, 200);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog: report a failure and stop once the cycle counter passes the limit.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic cfg_write(logic idx, logic [28:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait until every expected symbol has come out, then let the walk run dry.
    task automatic drain();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Offer one request; hold it until accepted. Gaps fall between bursts.
    task automatic send_byte(logic [7:0] b);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    // Build a random tree, its records and an encoded payload as one bit stream.
    // Variants: clean stream, late flipped payload bit, one byte short, looping tree.
    task automatic build_stream();
        int          n_leaf;
        int          root;
        int          node;
        int          shallow;
        int          a;
        int          b;
        int          pick;
        int          variant;
        int          target;
        int          x;
        int          payload_start;
        int          par [64];
        bit          pb [64];
        int          kid1 [64];
        int          kid0 [64];
        logic [7:0]  sym [64];
        int          depth [64];
        int          pool [$];
        bit          bits_q [$];
        bit          code [$];
        logic [31:0] size;
        logic [15:0] nc;
        logic [7:0]  acc_b;
        logic [9:0]  code1;
        logic [9:0]  code0;

        variant = $urandom_range(0, 9);
        n_leaf = $urandom_range(3, 12);
        for (int i = 0; i < n_leaf; i++) begin
            sym[i] = 8'($urandom_range(0, 255));
            kid1[i] = -1;
            kid0[i] = -1;
        end
        sym[0] = 8'h00;
        sym[1] = 8'hFF;
        for (int i = 0; i < n_leaf; i++) pool.push_back(i);
        node = n_leaf;
        while (pool.size() > 1) begin
            pick = $urandom_range(0, pool.size() - 1);
            a = pool[pick];
            pool.delete(pick);
            pick = $urandom_range(0, pool.size() - 1);
            b = pool[pick];
            pool.delete(pick);
            kid1[node] = a;
            kid0[node] = b;
            par[a] = node;
            pb[a] = 1'b1;
            par[b] = node;
            pb[b] = 1'b0;
            pool.push_back(node);
            node++;
        end
        root = node - 1;
        nc = 16'(root);

        shallow = 0;
        for (int i = 0; i < n_leaf; i++) begin
            depth[i] = 0;
            x = i;
            while (x != root) begin
                depth[i]++;
                x = par[x];
            end
            if (depth[i] < depth[shallow]) shallow = i;
        end

        // Loop a non-root internal node back to the root so the walk guard can trip.
        if (variant == 9) kid1[$urandom_range(n_leaf, root - 1)] = root;

        for (int i = 0; i <= root; i++) begin
            if (kid1[i] < 0) begin
                bits_q.push_back(1'b1);
                for (int k = 0; k < 8; k++) bits_q.push_back(sym[i][k]);
            end else begin
                bits_q.push_back(1'b0);
                code1 = 10'(2 * kid1[i] + 1);
                code0 = 10'(2 * kid0[i] + 1);
                for (int k = 0; k < 10; k++) bits_q.push_back(code1[k]);
                for (int k = 0; k < 10; k++) bits_q.push_back(code0[k]);
            end
        end
        payload_start = bits_q.size();

        // Favour the shortest code so the payload fits the header's length bound.
        target = $urandom_range(2800, 3500);
        size = 0;
        while (bits_q.size() - payload_start < target) begin
            pick = ($urandom_range(0, 1) == 0) ? shallow : $urandom_range(0, n_leaf - 1);
            code.delete();
            x = pick;
            while (x != root) begin
                code.push_front(pb[x]);
                x = par[x];
            end
            foreach (code[k]) bits_q.push_back(code[k]);
            size++;
        end
        while (bits_q.size() % 8 != 0) bits_q.push_back(1'($urandom_range(0, 1)));

        if (variant == 7) begin
            x = bits_q.size() - $urandom_range(1, bits_q.size() - payload_start) / 4 - 1;
            bits_q[x] = ~bits_q[x];
        end

        for (int k = 0; k < 4; k++) stream_q.push_back(size[8*k +: 8]);
        for (int k = 0; k < 2; k++) stream_q.push_back(nc[8*k +: 8]);
        for (int k = 0; k < 2; k++) stream_q.push_back(nc[8*k +: 8]);   // root index equals nc
        for (int i = 0; i < bits_q.size(); i += 8) begin
            for (int k = 0; k < 8; k++) acc_b[7 - k] = bits_q[i + k];
            stream_q.push_back(acc_b);
        end
        stream_len  = 28'(stream_q.size());
        stream_size = 29'(size);
        if (variant == 8) stream_len = stream_len - 28'd1;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_INPUT_LENGTH;
        cfg_wdata = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        build_stream();

        // Walk the registers through their extremes before settling on the stream's values.
        cfg_write(CFG_INPUT_LENGTH, 29'(MIN_IN_LEN));
        cfg_write(CFG_OUTPUT_LENGTH, 29'(MAX_OUT_SIZE));
        cfg_write(CFG_INPUT_LENGTH, 29'(MAX_IN_LEN));
        cfg_write(CFG_OUTPUT_LENGTH, 29'd1);
        cfg_write(CFG_INPUT_LENGTH, 29'(stream_len));
        cfg_write(CFG_OUTPUT_LENGTH, stream_size);

        foreach (stream_q[k]) begin
            if (k == stream_q.size() / 2) begin
                // Pause mid-payload: registers may change once the block is idle.
                s_tvalid <= 1'b0;
                drain();
                cfg_write(CFG_INPUT_LENGTH, 29'(MAX_IN_LEN));
                cfg_write(CFG_OUTPUT_LENGTH, 29'(MAX_OUT_SIZE));
                cfg_write(CFG_OUTPUT_LENGTH, 29'd1);
                cfg_write(CFG_INPUT_LENGTH, 29'(stream_len));
                burst_left = 0;
            end
            send_byte(stream_q[k]);
        end

        // Trailing bytes after the end of output must be dropped.
        send_byte(8'h00);
        send_byte(8'hFF);
        repeat (12) send_byte(8'($urandom_range(0, 255)));
        s_tvalid <= 1'b0;
        drain();

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- files.f -----
hdl/hts_pkg.sv
hdl/hts_node_mem.sv
hdl/hts_hdr_check.sv
hdl/huffman_tree_stream_decoder.sv
bench/hts_checker.sv
bench/tb_huffman_tree_stream_decoder.sv
